// File: design/gpp_pkg.sv
// Shared types, character codes and decimal tables for the GPRMC position parser.
package gpp_pkg;

    localparam int VALUE_W  = 34;
    localparam int FCNT_W   = 4;
    localparam int HDR_LEN  = 7;
    localparam int POW_W    = 27;
    localparam int LOW_W    = 30;

    localparam logic [VALUE_W-1:0] VALUE_MAX = 34'd9999999999;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_G      = 8'h47;
    localparam logic [7:0] CH_P      = 8'h50;
    localparam logic [7:0] CH_R      = 8'h52;
    localparam logic [7:0] CH_M      = 8'h4D;
    localparam logic [7:0] CH_C      = 8'h43;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_V      = 8'h56;
    localparam logic [7:0] CH_POINT  = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    localparam logic [1:0] ST_NONE  = 2'd0;
    localparam logic [1:0] ST_VALID = 2'd1;
    localparam logic [1:0] ST_NEVER = 2'd2;
    localparam logic [1:0] ST_STALE = 2'd3;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_TIME    = 3'd1,
        PH_STATUS  = 3'd2,
        PH_LAT     = 3'd3,
        PH_LAT_HEM = 3'd4,
        PH_LON     = 3'd5,
        PH_LON_HEM = 3'd6
    } phase_t;

    typedef struct packed {
        logic clear;
        logic feed;
    } num_ctrl_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [VALUE_W-1:0] lat;
        logic [7:0]         lat_hem;
        logic [VALUE_W-1:0] lon;
        logic [7:0]         lon_hem;
    } fix_t;

    function automatic logic [7:0] hdr_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = CH_DOLLAR;
            3'd1:    b = CH_G;
            3'd2:    b = CH_P;
            3'd3:    b = CH_R;
            3'd4:    b = CH_M;
            3'd5:    b = CH_C;
            3'd6:    b = CH_COMMA;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic [POW_W-1:0] pow10(input logic [FCNT_W-1:0] k);
        logic [POW_W-1:0] p;
        case (k)
            4'd0:    p = 27'd1;
            4'd1:    p = 27'd10;
            4'd2:    p = 27'd100;
            4'd3:    p = 27'd1000;
            4'd4:    p = 27'd10000;
            4'd5:    p = 27'd100000;
            4'd6:    p = 27'd1000000;
            4'd7:    p = 27'd10000000;
            4'd8:    p = 27'd100000000;
            default: p = 27'd1;
        endcase
        return p;
    endfunction

    // Largest value that still fits below VALUE_MAX after scaling by 10^k.
    function automatic logic [VALUE_W-1:0] limit10(input logic [FCNT_W-1:0] k);
        logic [VALUE_W-1:0] l;
        case (k)
            4'd0:    l = 34'd9999999999;
            4'd1:    l = 34'd999999999;
            4'd2:    l = 34'd99999999;
            4'd3:    l = 34'd9999999;
            4'd4:    l = 34'd999999;
            4'd5:    l = 34'd99999;
            4'd6:    l = 34'd9999;
            4'd7:    l = 34'd999;
            4'd8:    l = 34'd99;
            default: l = 34'd9999999999;
        endcase
        return l;
    endfunction

endpackage

// File: design/gpp_byte_if.sv
// Byte stream channel: valid, ready and one NMEA character.
interface gpp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

// File: design/gpp_fix_if.sv
// Fix result channel: valid, ready and the parsed position fields.
interface gpp_fix_if;
    logic        valid;
    logic        ready;
    logic [1:0]  fix_status;
    logic [33:0] latitude_scaled;
    logic [7:0]  latitude_hemisphere;
    logic [33:0] longitude_scaled;
    logic [7:0]  longitude_hemisphere;

    modport source (output valid, output fix_status, output latitude_scaled,
                    output latitude_hemisphere, output longitude_scaled,
                    output longitude_hemisphere, input ready);
    modport sink   (input valid, input fix_status, input latitude_scaled,
                    input latitude_hemisphere, input longitude_scaled,
                    input longitude_hemisphere, output ready);
endinterface

// File: design/gpp_num_acc.sv
// Decimal field accumulator with saturation and fixed-point scaling.
module gpp_num_acc
    import gpp_pkg::*;
#(
    parameter int FRAC_DIGITS = 5
) (
    input  logic               clk,
    input  logic               rst_n,
    input  num_ctrl_t          ctrl,
    input  logic [7:0]         char_in,
    output logic [VALUE_W-1:0] value
);

    logic [VALUE_W-1:0] acc_reg, acc_next;
    logic               point_reg, point_next;
    logic [FCNT_W-1:0]  fcnt_reg, fcnt_next;
    logic               stop_reg, stop_next;

    logic                 is_digit;
    logic [VALUE_W+3:0]   times_ten;
    logic [FCNT_W-1:0]    shift_k;
    logic [LOW_W+POW_W-1:0] product;

    assign is_digit  = (char_in >= CH_ZERO) && (char_in <= CH_NINE);
    assign times_ten = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0}
                     + {(VALUE_W - 4)'(0), (char_in - CH_ZERO)};

    always_comb
    begin
        acc_next   = acc_reg;
        point_next = point_reg;
        fcnt_next  = fcnt_reg;
        stop_next  = stop_reg;
        if (ctrl.clear)
        begin
            acc_next   = '0;
            point_next = 1'b0;
            fcnt_next  = '0;
            stop_next  = 1'b0;
        end
        else if (ctrl.feed && !stop_reg)
        begin
            if (is_digit)
            begin
                // drop digits past the kept fraction width
                if (!point_reg || (fcnt_reg < FCNT_W'(FRAC_DIGITS)))
                begin
                    if (point_reg)
                        fcnt_next = fcnt_reg + 1'b1;
                    acc_next = (times_ten > {4'b0000, VALUE_MAX}) ? VALUE_MAX
                             : times_ten[VALUE_W-1:0];
                end
            end
            else if ((char_in == CH_POINT) && !point_reg)
                point_next = 1'b1;
            else
                stop_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= '0;
            point_reg <= 1'b0;
            fcnt_reg  <= '0;
            stop_reg  <= 1'b0;
        end
        else
        begin
            acc_reg   <= acc_next;
            point_reg <= point_next;
            fcnt_reg  <= fcnt_next;
            stop_reg  <= stop_next;
        end
    end

    // Scale by the missing fraction digits; below the limit the value fits LOW_W bits.
    assign shift_k = FCNT_W'(FRAC_DIGITS) - fcnt_reg;
    assign product = acc_reg[LOW_W-1:0] * pow10(shift_k);

    always_comb
    begin
        if (shift_k == '0)
            value = acc_reg;
        else if (acc_reg > limit10(shift_k))
            value = VALUE_MAX;
        else
            value = product[VALUE_W-1:0];
    end

endmodule

// File: design/gpp_out_buf.sv
// Two-entry result buffer: output register plus skid register.
module gpp_out_buf
    import gpp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  fix_t push_data,
    output logic space,
    output logic out_valid,
    input  logic out_ready,
    output fix_t out_data
);

    logic main_valid_reg, main_valid_next;
    logic skid_valid_reg, skid_valid_next;
    fix_t main_reg, main_next;
    fix_t skid_reg, skid_next;
    logic pop;

    assign pop       = main_valid_reg && out_ready;
    assign space     = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (main_valid_reg && !pop)
            begin
                skid_next       = push_data;
                skid_valid_next = 1'b1;
            end
            else
            begin
                main_next       = push_data;
                main_valid_next = 1'b1;
            end
        end
        else if (pop)
            main_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

endmodule

// File: design/gprmc_position_parser_top.sv
// Top level of the streaming GPRMC position parser.
// A result item is registered into the output buffer on the byte that completes it.
// Throughput: one byte per cycle while ready is high; the phase register follows every accepted
// byte, the number accumulator the latitude and longitude bytes, and results collect in a two-entry output buffer.
// Ready drops only while both output entries hold untaken results.
// Reset (rst_n low, asynchronous) returns to header search and clears all state but the output buffer data registers.
module gprmc_position_parser_top
    import gpp_pkg::*;
#(
    parameter int FRAC_DIGITS = 5
) (
    input  logic        clk,
    input  logic        rst_n,
    gpp_byte_if.sink    nmea,
    gpp_fix_if.source   fix
);

    // Parser control state
    phase_t      phase_reg, phase_next;
    logic [2:0]  hdr_cnt_reg, hdr_cnt_next;
    logic [1:0]  sticky_reg, sticky_next;
    logic [7:0]  prev_reg;

    // Held fields of the sentence in progress
    logic [VALUE_W-1:0] lat_hold_reg, lat_hold_next;
    logic [7:0]         lat_hem_reg, lat_hem_next;
    logic [VALUE_W-1:0] lon_hold_reg, lon_hold_next;

    logic               accept;
    logic [7:0]         c;
    num_ctrl_t          num_ctrl;
    logic [VALUE_W-1:0] num_value;
    logic               push;
    fix_t               push_data;
    logic               space;
    fix_t               out_data;

    assign c      = nmea.in_byte;
    assign accept = nmea.valid && nmea.ready;
    assign nmea.ready = space;

    // Next phase and header match count
    always_comb
    begin
        phase_next   = phase_reg;
        hdr_cnt_next = hdr_cnt_reg;
        if (accept)
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    if (c == hdr_byte(hdr_cnt_reg))
                    begin
                        if (hdr_cnt_reg == 3'(HDR_LEN - 1))
                        begin
                            hdr_cnt_next = '0;
                            phase_next   = PH_TIME;
                        end
                        else
                            hdr_cnt_next = hdr_cnt_reg + 1'b1;
                    end
                    else
                        hdr_cnt_next = '0;
                end
                PH_TIME:
                    if (c == CH_COMMA)
                        phase_next = PH_STATUS;
                PH_STATUS:
                begin
                    if (c == CH_V)
                        phase_next = PH_HEADER;
                    else if (c == CH_COMMA)
                        phase_next = PH_LAT;
                end
                PH_LAT:
                    if (c == CH_COMMA)
                        phase_next = PH_LAT_HEM;
                PH_LAT_HEM:
                    if (c == CH_COMMA)
                        phase_next = PH_LON;
                PH_LON:
                    if (c == CH_COMMA)
                        phase_next = PH_LON_HEM;
                PH_LON_HEM:
                    if (c == CH_COMMA)
                        phase_next = PH_HEADER;
                default:
                    phase_next = PH_HEADER;
            endcase
        end
    end

    // Accumulator control, field holds, sticky status and result push
    always_comb
    begin
        num_ctrl      = '0;
        lat_hold_next = lat_hold_reg;
        lat_hem_next  = lat_hem_reg;
        lon_hold_next = lon_hold_reg;
        sticky_next   = sticky_reg;
        push          = 1'b0;
        push_data     = '0;
        if (accept)
        begin
            unique case (phase_reg)
                PH_STATUS:
                begin
                    if (c == CH_V)
                    begin
                        // never aligned before, or stale after a good fix
                        if (sticky_reg == ST_NONE)
                            sticky_next = ST_NEVER;
                        else if (sticky_reg == ST_VALID)
                            sticky_next = ST_STALE;
                        push             = 1'b1;
                        push_data.status = (sticky_reg == ST_NONE)  ? ST_NEVER :
                                           (sticky_reg == ST_VALID) ? ST_STALE :
                                           sticky_reg;
                    end
                    else if (c == CH_COMMA)
                        num_ctrl.clear = 1'b1;
                end
                PH_LAT:
                begin
                    if (c == CH_COMMA)
                        lat_hold_next = num_value;
                    else
                        num_ctrl.feed = 1'b1;
                end
                PH_LAT_HEM:
                begin
                    if (c == CH_COMMA)
                    begin
                        lat_hem_next   = prev_reg;
                        num_ctrl.clear = 1'b1;
                    end
                end
                PH_LON:
                begin
                    if (c == CH_COMMA)
                        lon_hold_next = num_value;
                    else
                        num_ctrl.feed = 1'b1;
                end
                PH_LON_HEM:
                begin
                    if (c == CH_COMMA)
                    begin
                        sticky_next       = ST_VALID;
                        push              = 1'b1;
                        push_data.status  = ST_VALID;
                        push_data.lat     = lat_hold_reg;
                        push_data.lat_hem = lat_hem_reg;
                        push_data.lon     = lon_hold_reg;
                        push_data.lon_hem = prev_reg;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HEADER;
            hdr_cnt_reg  <= '0;
            sticky_reg   <= ST_NONE;
            prev_reg     <= '0;
            lat_hold_reg <= '0;
            lat_hem_reg  <= '0;
            lon_hold_reg <= '0;
        end
        else
        begin
            phase_reg    <= phase_next;
            hdr_cnt_reg  <= hdr_cnt_next;
            sticky_reg   <= sticky_next;
            lat_hold_reg <= lat_hold_next;
            lat_hem_reg  <= lat_hem_next;
            lon_hold_reg <= lon_hold_next;
            // track the last byte for the hemisphere fields
            if (accept)
                prev_reg <= c;
        end
    end

    gpp_num_acc #(
        .FRAC_DIGITS (FRAC_DIGITS)
    ) u_num_acc (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (num_ctrl),
        .char_in (c),
        .value   (num_value)
    );

    gpp_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .space     (space),
        .out_valid (fix.valid),
        .out_ready (fix.ready),
        .out_data  (out_data)
    );

    assign fix.fix_status           = out_data.status;
    assign fix.latitude_scaled      = out_data.lat;
    assign fix.latitude_hemisphere  = out_data.lat_hem;
    assign fix.longitude_scaled     = out_data.lon;
    assign fix.longitude_hemisphere = out_data.lon_hem;

endmodule

// File: design/gpp_checker.sv
// Port-level assertions for the GPRMC position parser and their bind.
module gpp_checker
    import gpp_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               fix_valid,
    input logic               fix_ready,
    input logic [1:0]         fix_status,
    input logic [VALUE_W-1:0] lat,
    input logic [7:0]         lat_hem,
    input logic [VALUE_W-1:0] lon,
    input logic [7:0]         lon_hem
);

    logic seen_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seen_valid_reg <= 1'b0;
        else if (fix_valid && fix_ready && (fix_status == ST_VALID))
            seen_valid_reg <= 1'b1;
    end

    a_status_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        fix_valid |-> (fix_status != ST_NONE))
        else $error("result item with status none");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (fix_valid && (fix_status != ST_VALID))
            |-> ((lat == '0) && (lon == '0) && (lat_hem == '0) && (lon_hem == '0)))
        else $error("invalid fix carries coordinates");

    a_never_after_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (fix_valid && seen_valid_reg) |-> (fix_status != ST_NEVER))
        else $error("never-aligned status after a valid fix");

    a_saturated: assert property (@(posedge clk) disable iff (!rst_n)
        fix_valid |-> ((lat <= VALUE_MAX) && (lon <= VALUE_MAX)))
        else $error("coordinate above saturation limit");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (fix_valid && !fix_ready) |=> (fix_valid && $stable(fix_status)
            && $stable(lat) && $stable(lon) && $stable(lat_hem) && $stable(lon_hem)))
        else $error("stalled result item changed");

endmodule

bind gprmc_position_parser_top gpp_checker u_gpp_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .fix_valid  (fix.valid),
    .fix_ready  (fix.ready),
    .fix_status (fix.fix_status),
    .lat        (fix.latitude_scaled),
    .lat_hem    (fix.latitude_hemisphere),
    .lon        (fix.longitude_scaled),
    .lon_hem    (fix.longitude_hemisphere)
);
